@@ rtl/newton_square_root_unit_macros.svh @@
// Assertion macros shared by the square root unit.
// Used by newton_square_root_unit only; no other dependencies.
`ifndef NEWTON_SQUARE_ROOT_UNIT_MACROS_SVH
`define NEWTON_SQUARE_ROOT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define NSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nsr assertion failed");

// Next-cycle implication, disabled while reset is low
`define NSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nsr assertion failed");

`endif

@@ rtl/nsr_pkg.sv @@
// Shared constants, types and codes for the Newton square root unit.
// No dependencies; imported by every module of the block.
package nsr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_ITER  = 32;

  localparam int VALUE_W  = 32;
  localparam int ROOT_W   = 24;
  localparam int STATUS_W = 2;
  localparam int TOL_W    = 17;
  localparam int GUESS_W  = 32;

  // Dividend is the non-negative value shifted up by the fraction bits,
  // padded to an even width so the divider retires two bits a cycle
  localparam int DIVD_W     = 2 * ((VALUE_W - 1 + FRAC_BITS + 1) / 2);
  localparam int DIV_STEPS  = DIVD_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int ITER_W     = $clog2(MAX_ITER + 1);

  localparam logic [GUESS_W-1:0] GUESS_ONE = GUESS_W'(1) << FRAC_BITS;
  localparam logic [ROOT_W-1:0]  ROOT_MAX  = {ROOT_W{1'b1}};
  localparam logic [TOL_W-1:0]   TOL_RESET = TOL_W'(1);

  typedef enum logic [STATUS_W-1:0] {
    ST_CONVERGED = 2'd0,
    ST_INVALID   = 2'd1,
    ST_LIMIT     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_CHECK,
    S_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic update;
    logic emit;
  } nsr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic neg;
    logic trivial;
    logic div_done;
    logic conv;
  } nsr_sts_t;

endpackage

@@ rtl/nsr_div.sv @@
// Restoring unsigned divider, two quotient bits per cycle.
// Depends on nsr_pkg for widths and step count.
module nsr_div
  import nsr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIVD_W-1:0]  dividend,
  input  logic [GUESS_W-1:0] divisor,
  output logic               done,
  output logic [DIVD_W-1:0]  quotient
);

  logic [GUESS_W-1:0]   rem_r,  rem_nxt;
  logic [DIVD_W-1:0]    quo_r,  quo_nxt;
  logic [GUESS_W-1:0]   dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [GUESS_W:0] trial1, trial2;
  logic [GUESS_W:0] part1, part2;
  logic             bit1, bit2;

  always_comb begin
    trial1 = {rem_r, quo_r[DIVD_W-1]};
    bit1   = (trial1 >= {1'b0, dsr_r});
    part1  = bit1 ? (trial1 - {1'b0, dsr_r}) : trial1;
    trial2 = {part1[GUESS_W-1:0], quo_r[DIVD_W-2]};
    bit2   = (trial2 >= {1'b0, dsr_r});
    part2  = bit2 ? (trial2 - {1'b0, dsr_r}) : trial2;
    rem_nxt = part2[GUESS_W-1:0];
    quo_nxt = {quo_r[DIVD_W-3:0], bit1, bit2};
  end

  // Datapath registers: load on start, shift while busy
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/nsr_datapath.sv @@
// Datapath: operand, guess pair, tolerance register, divider and convergence test.
// Depends on nsr_pkg and instantiates nsr_div.
module nsr_datapath
  import nsr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  nsr_cmd_t           cmd,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               cfg_we,
  input  logic [TOL_W-1:0]   cfg_tol,
  output nsr_sts_t           sts,
  output logic [ROOT_W-1:0]  root
);

  logic [VALUE_W-1:0] raw_r;
  logic [GUESS_W-1:0] last_r;
  logic [GUESS_W-1:0] next_r, next_nxt;
  logic [TOL_W-1:0]   tol_r;

  logic               in_neg, in_trivial;
  logic [DIVD_W-1:0]  dividend;
  logic [DIVD_W-1:0]  quotient;
  logic               div_done;
  logic [DIVD_W:0]    sum;
  logic [GUESS_W-1:0] diff;

  assign in_neg     = in_value[VALUE_W-1];
  assign in_trivial = (in_value == '0) || (in_value == VALUE_W'(GUESS_ONE));

  // value << FRAC_BITS, sign bit known clear here
  assign dividend = DIVD_W'(raw_r[VALUE_W-2:0]) << FRAC_BITS;

  nsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (next_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // Average of guess and quotient, rounded down
  assign sum = (DIVD_W + 1)'(next_r) + (DIVD_W + 1)'(quotient);

  always_comb begin
    next_nxt = next_r;
    if (cmd.load) begin
      // Guess doubles as the result: zero when negative, value when trivial
      if (in_neg) begin
        next_nxt = '0;
      end else if (in_trivial) begin
        next_nxt = in_value[GUESS_W-1:0];
      end else begin
        next_nxt = GUESS_ONE;
      end
    end else if (cmd.update) begin
      next_nxt = sum[GUESS_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_r <= in_value;
    end
    if (cmd.update) begin
      last_r <= next_r;
    end
    next_r <= next_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_tol;
    end
  end

  assign diff = (last_r >= next_r) ? (last_r - next_r) : (next_r - last_r);

  assign sts.neg      = raw_r[VALUE_W-1];
  assign sts.trivial  = (raw_r == '0) || (raw_r == VALUE_W'(GUESS_ONE));
  assign sts.div_done = div_done;
  assign sts.conv     = (diff <= GUESS_W'(tol_r));

  assign root = (next_r > GUESS_W'(ROOT_MAX)) ? ROOT_MAX : next_r[ROOT_W-1:0];

endmodule

@@ rtl/nsr_ctrl.sv @@
// Controller state machine: sequences load, Newton steps and result hand-off.
// Depends on nsr_pkg for state, status and command types.
module nsr_ctrl
  import nsr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     out_free,
  input  nsr_sts_t sts,
  output logic     in_ready,
  output nsr_cmd_t cmd,
  output status_t  status
);

  state_t              state_r,  state_nxt;
  logic [ITER_W-1:0]   iter_r,   iter_nxt;
  status_t             status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      iter_r   <= '0;
      status_r <= ST_CONVERGED;
    end else begin
      state_r  <= state_nxt;
      iter_r   <= iter_nxt;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    iter_nxt   = iter_r;
    status_nxt = status_r;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts.neg) begin
          status_nxt = ST_INVALID;
          state_nxt  = S_EMIT;
        end else if (sts.trivial) begin
          status_nxt = ST_CONVERGED;
          state_nxt  = S_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          iter_nxt      = '0;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.update = 1'b1;
          iter_nxt   = iter_r + ITER_W'(1);
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.conv) begin
          status_nxt = ST_CONVERGED;
          state_nxt  = S_EMIT;
        end else if (iter_r >= ITER_W'(MAX_ITER)) begin
          status_nxt = ST_LIMIT;
          state_nxt  = S_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign status = status_r;

endmodule

@@ rtl/newton_square_root_unit.sv @@
// Newton-Raphson square root of a signed Q16.16 beat, result in unsigned Q8.16.
// Top level: joins nsr_ctrl and nsr_datapath; uses nsr_pkg and the assertion macros.
//
// Usage:
//   in_*  : one beat carries the value (signed Q16.16) in in_tdata.
//   out_* : one beat per input; out_tdata holds the root, out_tuser the status
//           (converged, negative input invalid, iteration limit reached).
//   cfg_* : writes the 17-bit tolerance; cfg_ready is always high. Write only
//           while the unit is idle. Tolerance resets to one LSB.
// Sequencing: negative, zero and one inputs skip the divider and pass from the
//   load state straight to emit. Otherwise each Newton step runs the shared
//   radix-4 divider, which retires two quotient bits a cycle, plus the start
//   and check cycles; an item takes at most MAX_ITER steps.
// One item is in flight at a time; in_tready is high only between items. A
//   finished result sits in the output register, so a new beat is accepted
//   while it waits; a second result holds the controller until out_tready.
// Reset (synchronous, active low) drops any item in progress and empties the
//   output register.
`include "newton_square_root_unit_macros.svh"

module newton_square_root_unit
  import nsr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Input channel
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [VALUE_W-1:0]  in_tdata,   // [31:0] value
  // Result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [ROOT_W-1:0]   out_tdata,  // [23:0] root
  output logic [STATUS_W-1:0] out_tuser,  // [1:0] status
  // Configuration channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TOL_W-1:0]    cfg_data    // [16:0] tolerance
);

  nsr_cmd_t cmd;
  nsr_sts_t sts;
  status_t  status;
  logic [ROOT_W-1:0] root;
  logic              out_free;

  logic                out_valid_r;
  logic [ROOT_W-1:0]   out_root_r;
  logic [STATUS_W-1:0] out_status_r;

  // Output register may be refilled once the waiting beat leaves
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  nsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd),
    .status   (status)
  );

  nsr_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_value (in_tdata),
    .cfg_we   (cfg_valid),
    .cfg_tol  (cfg_data),
    .sts      (sts),
    .root     (root)
  );

  // Result payload: capture on emit, hold otherwise
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_root_r   <= root;
      out_status_r <= status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_root_r;
  assign out_tuser  = out_status_r;

  // An invalid result always carries a zero root
  `NSR_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_valid_r && (out_status_r == ST_INVALID), out_root_r == '0)
  // Accepting a beat closes the input until the item is finished
  `NSR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // Never overwrite a result still waiting for the receiver
  `NSR_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.emit, !(out_valid_r && !out_tready))

endmodule

@@ test/tb.sv @@
// Self-checking testbench for newton_square_root_unit, the Newton square root of signed Q16.16.
// Depends on nsr_pkg and the RTL only; drives stream beats and tolerance writes, checks each root.
`timescale 1ns / 1ps

module tb;
  import nsr_pkg::*;

  localparam int STALL_LIMIT = 5000;   // covers one capped item plus idle bursts
  localparam int PRINT_CAP   = 200;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    status_t           status;
  } root_beat_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [VALUE_W-1:0]  in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [ROOT_W-1:0]   out_tdata;
  logic [STATUS_W-1:0] out_tuser;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [TOL_W-1:0]    cfg_data   = '0;

  logic [VALUE_W-1:0] value_q[$];      // values waiting to be driven
  root_beat_t         root_q[$];       // roots owed by the unit, oldest first
  logic [TOL_W-1:0]   tol_copy = TOL_RESET;
  int                 queued_count   = 0;
  int                 accepted_count = 0;
  int                 error_count    = 0;
  int                 in_idle_pct    = 0;
  int                 out_idle_pct   = 0;
  int                 in_gap         = 0;
  int                 out_gap        = 0;
  int                 stall_cycles   = 0;

  newton_square_root_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [31:0] value
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [23:0] root
    .out_tuser  (out_tuser),   // [1:0] status
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)     // [16:0] tolerance
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // One Newton update: average the guess with value/guess, halving rounds down.
  // A zero guess is lifted to one unit in the last place.
  function automatic logic [63:0] newton_update(logic [63:0] num, logic [63:0] guess);
    logic [63:0] g;
    logic [63:0] q;
    g = (guess == 64'd0) ? 64'd1 : guess;
    q = (num << FRAC_BITS) / g;
    return (g + q) >> 1;
  endfunction

  // Work out the root beat owed for one value under the given tolerance.
  function automatic root_beat_t predict_root(logic [VALUE_W-1:0] value,
                                              logic [TOL_W-1:0] tol);
    root_beat_t  beat;
    logic [63:0] raw;
    logic [63:0] prev;
    logic [63:0] guess;
    logic [63:0] diff;
    int          steps;
    bit          done;
    raw = {32'd0, value};
    beat.status = ST_CONVERGED;
    if (value[VALUE_W-1]) begin
      beat.root   = '0;
      beat.status = ST_INVALID;
      return beat;
    end
    // Zero and exactly one pass straight through
    if (raw == 64'd0 || raw == {32'd0, GUESS_ONE}) begin
      beat.root = raw[ROOT_W-1:0];
      return beat;
    end
    // The first step from a guess of one always counts as iteration one
    prev  = {32'd0, GUESS_ONE};
    guess = newton_update(raw, prev);
    steps = 1;
    done  = 1'b0;
    while (!done) begin
      diff = (prev > guess) ? (prev - guess) : (guess - prev);
      if (diff <= {47'd0, tol}) begin
        done = 1'b1;
      end else if (steps >= MAX_ITER) begin
        beat.status = ST_LIMIT;
        done = 1'b1;
      end else begin
        prev  = guess;
        guess = newton_update(raw, guess);
        steps++;
      end
    end
    // Saturate a guess too wide for the root field
    beat.root = (guess > {40'd0, ROOT_MAX}) ? ROOT_MAX : guess[ROOT_W-1:0];
    return beat;
  endfunction

  task automatic report_mismatch(string msg);
    if (error_count < PRINT_CAP) $display("tb: mismatch: %s", msg);
    error_count++;
  endtask

  // Input driver: present queued values, hold each until accepted, insert idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        root_q.push_back(predict_root(in_tdata, tol_copy));
        accepted_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (value_q.size() > 0) begin
          in_tdata  <= value_q.pop_front();
          in_tvalid <= 1'b1;
          if ($urandom_range(0, 99) < in_idle_pct) in_gap <= $urandom_range(1, 11);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each root beat with the oldest owed one, stall at random.
  always @(posedge clk) begin
    root_beat_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (root_q.size() == 0) begin
          report_mismatch($sformatf("unexpected root beat %h status %0d", out_tdata, out_tuser));
        end else begin
          want = root_q.pop_front();
          if (out_tdata !== want.root)
            report_mismatch($sformatf("root %h, want %h", out_tdata, want.root));
          if (out_tuser !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_tuser, want.status));
        end
      end
      if (out_gap > 0) begin
        out_gap    <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 99) < out_idle_pct) out_gap <= $urandom_range(1, 11);
      end
    end
  end

  // Track the tolerance the unit holds
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) tol_copy <= cfg_data;
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Spread magnitudes widely: negatives, tiny values, the trivial ones and their neighbours, shifted randoms
  function automatic logic [VALUE_W-1:0] draw_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = $urandom | 32'h8000_0000;
      1: v = $urandom_range(0, 32'h3_FFFF);
      2: begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = GUESS_ONE;
          2: v = GUESS_ONE - 1;
          default: v = GUESS_ONE + 1;
        endcase
      end
      default: v = ($urandom & 32'h7FFF_FFFF) >> $urandom_range(0, 30);
    endcase
    return v;
  endfunction

  task automatic queue_value(logic [VALUE_W-1:0] v);
    value_q.push_back(v);
    queued_count++;
  endtask

  // Hold until every queued value is in and every owed root is out
  task automatic drain();
    while (accepted_count != queued_count || root_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] tol);
    drain();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= tol;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [TOL_W-1:0] tol, int count, int in_pct, int out_pct);
    write_tolerance(tol);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    repeat (count) queue_value(draw_value());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats under the reset tolerance: extremes, trivial inputs, negatives
    in_idle_pct  = 30;
    out_idle_pct = 30;
    queue_value(32'h0000_0000);
    queue_value(GUESS_ONE);
    queue_value(32'hFFFF_FFFF);
    queue_value(32'h8000_0000);
    queue_value(32'h7FFF_FFFF);
    queue_value(32'h0000_0001);
    queue_value(32'h0000_0002);
    queue_value(32'h0000_FFFF);
    queue_value(32'h0001_0001);
    queue_value(32'h0002_0000);
    queue_value(32'h0004_0000);
    queue_value(32'h0009_0000);
    queue_value(32'h5555_5555);
    queue_value(32'hAAAA_AAAA);
    queue_value(32'h7FFF_0000);
    queue_value(32'h0000_0100);

    // Zero tolerance: equal guesses needed, oscillation runs into the iteration cap
    write_tolerance('0);
    queue_value(32'h0002_0000);
    queue_value(32'h0003_0000);
    queue_value(32'h7FFF_FFFF);
    queue_value(32'h0000_0005);
    queue_value(32'h0001_0001);

    run_phase('0, 100, 20, 20);
    run_phase(TOL_W'(65536), 150, 0, 40);
    run_phase({TOL_W{1'b1}}, 80, 40, 0);
    repeat (3) run_phase(TOL_W'($urandom_range(1, 65536)), 150, 25, 25);

    // Close with the reset tolerance and no idling on either side
    run_phase(TOL_RESET, 200, 0, 0);
    drain();
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
